// File: src/mcht_pkg.sv
// shared types, widths and helpers for the monotone convex hull trick block
// no dependencies
`timescale 1ns / 1ps

package mcht_pkg;

	localparam int DEPTH   = 1024;
	localparam int AW      = $clog2(DEPTH);
	localparam int CW      = $clog2(DEPTH + 1);
	localparam int SLOPE_W = 32;
	localparam int ICPT_W  = 56;
	localparam int POINT_W = 32;
	localparam int VAL_W   = 64;
	localparam int LINE_W  = SLOPE_W + ICPT_W;
	localparam int DA_W    = ICPT_W + 1;
	localparam int DM_W    = SLOPE_W + 1;
	localparam int LO_W    = 29;
	localparam int MA_W    = LO_W + 1;
	localparam int PP_W    = MA_W + DM_W;
	localparam int PROD_W  = DA_W + DM_W + 1;

	localparam logic ACT_ADD   = 1'b0;
	localparam logic ACT_QUERY = 1'b1;

	localparam logic signed [VAL_W-1:0] EMPTY_VALUE = 64'sd1000000000000000000;

	typedef struct packed {
		logic                       action;
		logic signed [SLOPE_W-1:0]  slope;
		logic signed [ICPT_W-1:0]   intercept;
		logic signed [POINT_W-1:0]  point;
	} item_t;

	// (front + k) mod DEPTH, with k no larger than DEPTH
	function automatic logic [AW-1:0] slot(input logic [AW-1:0] front, input logic [CW-1:0] k);
		logic [AW+1:0] sum;
		sum = (AW+2)'(front) + (AW+2)'(k);
		if (sum >= (AW+2)'(DEPTH)) begin
			sum = sum - (AW+2)'(DEPTH);
		end
		return sum[AW-1:0];
	endfunction

endpackage

// File: src/mcht_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module mcht_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: src/mcht_front.sv
// front end: takes requests and holds them in a two entry queue for the engine
// depends on mcht_pkg
`timescale 1ns / 1ps

module mcht_front (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic                               action,
	input  logic signed [mcht_pkg::SLOPE_W-1:0] slope,
	input  logic signed [mcht_pkg::ICPT_W-1:0]  intercept,
	input  logic signed [mcht_pkg::POINT_W-1:0] point,
	output logic                               q_valid,
	output mcht_pkg::item_t                    q_item,
	input  logic                               q_pop
);

	mcht_pkg::item_t ent_q [2];
	logic            wr_ptr_q;
	logic            rd_ptr_q;
	logic [1:0]      cnt_q;
	logic            push;
	logic            pop;
	mcht_pkg::item_t in_item;

	always_comb begin
		in_item.action    = (action == mcht_pkg::ACT_QUERY) ? mcht_pkg::ACT_QUERY
		                                                    : mcht_pkg::ACT_ADD;
		in_item.slope     = slope;
		in_item.intercept = intercept;
		in_item.point     = point;
	end

	assign busy    = (cnt_q == 2'd2);
	assign push    = start && !busy;
	assign q_valid = (cnt_q != 2'd0);
	assign pop     = q_pop && q_valid;
	assign q_item  = ent_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

endmodule

// File: src/mcht_back.sv
// engine: runs adds and queries against the line store, one request at a time
// depends on mcht_pkg and mcht_ram
`timescale 1ns / 1ps

module mcht_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              q_valid,
	input  mcht_pkg::item_t                   q_item,
	output logic                              q_pop,
	output logic                              done,
	output logic signed [mcht_pkg::VAL_W-1:0] min_value,
	output logic                              hull_empty,
	output logic                              add_refused
);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_A_RD2 = 4'd1;
	localparam logic [3:0] ST_A_RD1 = 4'd2;
	localparam logic [3:0] ST_A_CAP = 4'd3;
	localparam logic [3:0] ST_A_MUL = 4'd4;
	localparam logic [3:0] ST_A_CMP = 4'd5;
	localparam logic [3:0] ST_A_WR  = 4'd6;
	localparam logic [3:0] ST_Q_ST  = 4'd7;
	localparam logic [3:0] ST_Q_V0  = 4'd8;
	localparam logic [3:0] ST_Q_V1  = 4'd9;
	localparam logic [3:0] ST_Q_CMP = 4'd10;
	localparam logic [3:0] ST_Q_OUT = 4'd11;

	logic [3:0]                 state_q;
	logic [mcht_pkg::AW-1:0]    front_q;
	logic [mcht_pkg::CW-1:0]    count_q;
	logic [1:0]                 mul_cnt_q;
	mcht_pkg::item_t            it_q;

	logic signed [mcht_pkg::SLOPE_W-1:0] m2_q;
	logic signed [mcht_pkg::ICPT_W-1:0]  b2_q;
	logic signed [mcht_pkg::DA_W-1:0]    da1_q, da2_q;
	logic signed [mcht_pkg::DM_W-1:0]    dm1_q, dm2_q;
	logic signed [mcht_pkg::PROD_W-1:0]  p1_q, p2_q;
	logic signed [mcht_pkg::VAL_W-1:0]   v0_q, v1_q;

	logic                               done_q;
	logic signed [mcht_pkg::VAL_W-1:0]  min_value_q;
	logic                               hull_empty_q;
	logic                               add_refused_q;

	logic                               we;
	logic [mcht_pkg::AW-1:0]            waddr;
	logic [mcht_pkg::AW-1:0]            raddr;
	logic [mcht_pkg::LINE_W-1:0]        rdata;
	logic signed [mcht_pkg::SLOPE_W-1:0] rd_m;
	logic signed [mcht_pkg::ICPT_W-1:0]  rd_b;
	logic signed [mcht_pkg::VAL_W-1:0]  mx;
	logic signed [mcht_pkg::VAL_W-1:0]  val;
	logic signed [mcht_pkg::DA_W-1:0]   mul_da;
	logic signed [mcht_pkg::MA_W-1:0]   mul_a;
	logic signed [mcht_pkg::DM_W-1:0]   mul_b;
	logic signed [mcht_pkg::PP_W-1:0]   prod;
	logic signed [mcht_pkg::PROD_W-1:0] part;

	assign rd_m = rdata[mcht_pkg::LINE_W-1:mcht_pkg::ICPT_W];
	assign rd_b = rdata[mcht_pkg::ICPT_W-1:0];

	// line value at the query point; wraps to 64 bits
	assign mx  = rd_m * it_q.point;
	assign val = mx + mcht_pkg::VAL_W'(rd_b);

	// one partial product a cycle: low half, then high half, first product then second
	assign mul_da = mul_cnt_q[1] ? da2_q : da1_q;
	assign mul_b  = mul_cnt_q[1] ? dm2_q : dm1_q;
	assign mul_a  = mul_cnt_q[0]
		? mcht_pkg::MA_W'($signed(mul_da[mcht_pkg::DA_W-1:mcht_pkg::LO_W]))
		: $signed({1'b0, mul_da[mcht_pkg::LO_W-1:0]});
	assign prod   = mul_a * mul_b;
	assign part   = mul_cnt_q[0] ? (mcht_pkg::PROD_W'(prod) <<< mcht_pkg::LO_W)
	                             : mcht_pkg::PROD_W'(prod);

	always_comb begin
		raddr = front_q;
		we    = 1'b0;
		waddr = mcht_pkg::slot(front_q, count_q);
		q_pop = 1'b0;
		unique case (state_q)
			ST_IDLE:  q_pop = q_valid;
			ST_A_RD2: raddr = mcht_pkg::slot(front_q, count_q - mcht_pkg::CW'(1));
			ST_A_RD1: raddr = mcht_pkg::slot(front_q, count_q - mcht_pkg::CW'(2));
			ST_A_WR:  we = 1'b1;
			ST_Q_V0:  raddr = mcht_pkg::slot(front_q, mcht_pkg::CW'(1));
			default:  raddr = front_q;
		endcase
	end

	mcht_ram #(
		.WIDTH(mcht_pkg::LINE_W),
		.DEPTH(mcht_pkg::DEPTH)
	) u_store (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata({it_q.slope, it_q.intercept}),
		.raddr(raddr),
		.rdata(rdata)
	);

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					it_q <= q_item;
				end
			end
			ST_A_RD1: begin
				m2_q <= rd_m;
				b2_q <= rd_b;
			end
			ST_A_CAP: begin
				da1_q <= mcht_pkg::DA_W'(b2_q) - mcht_pkg::DA_W'(rd_b);
				dm1_q <= mcht_pkg::DM_W'(m2_q) - mcht_pkg::DM_W'(it_q.slope);
				da2_q <= mcht_pkg::DA_W'(b2_q) - mcht_pkg::DA_W'(it_q.intercept);
				dm2_q <= mcht_pkg::DM_W'(m2_q) - mcht_pkg::DM_W'(rd_m);
			end
			ST_A_MUL: begin
				case (mul_cnt_q)
					2'd0:    p1_q <= part;
					2'd1:    p1_q <= p1_q + part;
					2'd2:    p2_q <= part;
					default: p2_q <= p2_q + part;
				endcase
			end
			ST_Q_V0: v0_q <= val;
			ST_Q_V1: v1_q <= val;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			front_q       <= '0;
			count_q       <= '0;
			mul_cnt_q     <= '0;
			done_q        <= 1'b0;
			min_value_q   <= '0;
			hull_empty_q  <= 1'b0;
			add_refused_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						if (q_item.action == mcht_pkg::ACT_QUERY) begin
							state_q <= ST_Q_ST;
						end else if (count_q < mcht_pkg::CW'(2)) begin
							state_q <= ST_A_WR;
						end else begin
							state_q <= ST_A_RD2;
						end
					end
				end
				ST_A_RD2: state_q <= ST_A_RD1;
				ST_A_RD1: state_q <= ST_A_CAP;
				ST_A_CAP: begin
					mul_cnt_q <= '0;
					state_q   <= ST_A_MUL;
				end
				ST_A_MUL: begin
					mul_cnt_q <= mul_cnt_q + 2'd1;
					if (mul_cnt_q == 2'd3) begin
						state_q <= ST_A_CMP;
					end
				end
				ST_A_CMP: begin
					if (p1_q >= p2_q) begin
						// middle line is useless: drop the back line and test again if two lines remain
						count_q <= count_q - mcht_pkg::CW'(1);
						state_q <= (count_q > mcht_pkg::CW'(2)) ? ST_A_RD2 : ST_A_WR;
					end else if (count_q >= mcht_pkg::CW'(mcht_pkg::DEPTH)) begin
						done_q        <= 1'b1;
						min_value_q   <= '0;
						hull_empty_q  <= 1'b0;
						add_refused_q <= 1'b1;
						state_q       <= ST_IDLE;
					end else begin
						state_q <= ST_A_WR;
					end
				end
				ST_A_WR: begin
					count_q       <= count_q + mcht_pkg::CW'(1);
					done_q        <= 1'b1;
					min_value_q   <= '0;
					hull_empty_q  <= 1'b0;
					add_refused_q <= 1'b0;
					state_q       <= ST_IDLE;
				end
				ST_Q_ST: begin
					if (count_q == '0) begin
						done_q        <= 1'b1;
						min_value_q   <= mcht_pkg::EMPTY_VALUE;
						hull_empty_q  <= 1'b1;
						add_refused_q <= 1'b0;
						state_q       <= ST_IDLE;
					end else begin
						state_q <= ST_Q_V0;
					end
				end
				ST_Q_V0: state_q <= (count_q >= mcht_pkg::CW'(2)) ? ST_Q_V1 : ST_Q_OUT;
				ST_Q_V1: state_q <= ST_Q_CMP;
				ST_Q_CMP: begin
					if (v0_q >= v1_q) begin
						front_q <= mcht_pkg::slot(front_q, mcht_pkg::CW'(1));
						count_q <= count_q - mcht_pkg::CW'(1);
						state_q <= ST_Q_ST;
					end else begin
						state_q <= ST_Q_OUT;
					end
				end
				ST_Q_OUT: begin
					done_q        <= 1'b1;
					min_value_q   <= v0_q;
					hull_empty_q  <= 1'b0;
					add_refused_q <= 1'b0;
					state_q       <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign done        = done_q;
	assign min_value   = min_value_q;
	assign hull_empty  = hull_empty_q;
	assign add_refused = add_refused_q;

endmodule

// File: src/monotone_convex_hull_trick.sv
// monotone convex hull trick, minimum queries; requests queue two deep ahead of the engine.
// add: each back-pop test takes two reads, a capture and four partial products of the shared 30x33
// multiplier, then a compare; the line is then written, or refused when the store is full.
// query: pops the front line while the next line is no higher at the point; one request at a
// time in the engine.
// arst_n clears the hull and the queue, not the line memory; done results cannot be held off.
`timescale 1ns / 1ps

module monotone_convex_hull_trick (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic                               action,
	input  logic signed [mcht_pkg::SLOPE_W-1:0] slope,
	input  logic signed [mcht_pkg::ICPT_W-1:0]  intercept,
	input  logic signed [mcht_pkg::POINT_W-1:0] point,
	output logic                               done,
	output logic signed [mcht_pkg::VAL_W-1:0]   min_value,
	output logic                               hull_empty,
	output logic                               add_refused
);

	logic            q_valid;
	logic            q_pop;
	mcht_pkg::item_t q_item;

	mcht_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.action   (action),
		.slope    (slope),
		.intercept(intercept),
		.point    (point),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.q_pop    (q_pop)
	);

	mcht_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_valid),
		.q_item     (q_item),
		.q_pop      (q_pop),
		.done       (done),
		.min_value  (min_value),
		.hull_empty (hull_empty),
		.add_refused(add_refused)
	);

endmodule

// File: tb/sv/tb.sv
// self-checking testbench for monotone_convex_hull_trick: directed and random add/query requests
// depends on mcht_pkg and monotone_convex_hull_trick
`timescale 1ns / 1ps

module tb;

	localparam int WATCHDOG_LIMIT = 100000;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic action;
	logic signed [mcht_pkg::SLOPE_W-1:0] slope;
	logic signed [mcht_pkg::ICPT_W-1:0] intercept;
	logic signed [mcht_pkg::POINT_W-1:0] point;
	logic done;
	logic signed [mcht_pkg::VAL_W-1:0] min_value;
	logic hull_empty;
	logic add_refused;

	typedef struct {
		logic signed [mcht_pkg::VAL_W-1:0] value;
		logic empty;
		logic refused;
	} hull_result_t;

	// predicted hull, mirrors the block's circular line store
	logic signed [mcht_pkg::SLOPE_W-1:0] hull_slope [mcht_pkg::DEPTH];
	logic signed [mcht_pkg::ICPT_W-1:0] hull_icpt [mcht_pkg::DEPTH];
	int hull_front;
	int hull_count;
	hull_result_t pending_results[$];

	int mismatches;
	int results_seen;
	int adds_sent;
	int queries_sent;
	int refusals_seen;
	int empties_seen;
	int idle_cycles;
	bit timed_out;
	bit no_gaps;
	logic signed [mcht_pkg::POINT_W-1:0] last_point;
	logic signed [mcht_pkg::SLOPE_W-1:0] last_slope;

	monotone_convex_hull_trick dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .action(action),
		.slope(slope), .intercept(intercept), .point(point), .done(done),
		.min_value(min_value), .hull_empty(hull_empty), .add_refused(add_refused)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic int hull_slot(int k);
		return (hull_front + k) % mcht_pkg::DEPTH;
	endfunction

	function automatic logic signed [mcht_pkg::VAL_W-1:0] line_at(int s,
			logic signed [mcht_pkg::POINT_W-1:0] x);
		logic signed [mcht_pkg::VAL_W-1:0] v;
		v = mcht_pkg::VAL_W'(hull_slope[s]) * mcht_pkg::VAL_W'(x)
			+ mcht_pkg::VAL_W'(hull_icpt[s]);
		return v;
	endfunction

	// true when the last line is useless once the new line (m3,b3) arrives
	function automatic bit back_pop(logic signed [mcht_pkg::SLOPE_W-1:0] m3,
			logic signed [mcht_pkg::ICPT_W-1:0] b3);
		logic signed [127:0] m1, b1, m2, b2, lhs, rhs;
		int s1, s2;
		if (hull_count < 2) return 1'b0;
		s1 = hull_slot(hull_count - 2);
		s2 = hull_slot(hull_count - 1);
		m1 = 128'(hull_slope[s1]);
		b1 = 128'(hull_icpt[s1]);
		m2 = 128'(hull_slope[s2]);
		b2 = 128'(hull_icpt[s2]);
		lhs = (b2 - b1) * (m2 - 128'(m3));
		rhs = (b2 - 128'(b3)) * (m2 - m1);
		return lhs >= rhs;
	endfunction

	function automatic hull_result_t predict_hull(logic act,
			logic signed [mcht_pkg::SLOPE_W-1:0] m,
			logic signed [mcht_pkg::ICPT_W-1:0] b,
			logic signed [mcht_pkg::POINT_W-1:0] x);
		hull_result_t r;
		int s;
		r.value = '0;
		r.empty = 1'b0;
		r.refused = 1'b0;
		if (act == mcht_pkg::ACT_ADD) begin
			if (hull_count >= mcht_pkg::DEPTH && !back_pop(m, b)) begin
				r.refused = 1'b1;
			end else begin
				while (back_pop(m, b)) hull_count--;
				s = hull_slot(hull_count);
				hull_slope[s] = m;
				hull_icpt[s] = b;
				hull_count++;
			end
		end else begin
			while (hull_count >= 2 && line_at(hull_slot(0), x) >= line_at(hull_slot(1), x)) begin
				hull_front = (hull_front + 1) % mcht_pkg::DEPTH;
				hull_count--;
			end
			if (hull_count == 0) begin
				r.value = mcht_pkg::EMPTY_VALUE;
				r.empty = 1'b1;
			end else begin
				r.value = line_at(hull_slot(0), x);
			end
		end
		return r;
	endfunction

	// start stays high after acceptance; a drain, or a gap before the next request, drops it
	task automatic send_request(logic act, logic signed [mcht_pkg::SLOPE_W-1:0] m,
			logic signed [mcht_pkg::ICPT_W-1:0] b, logic signed [mcht_pkg::POINT_W-1:0] x);
		while (!no_gaps && $urandom_range(99) < 25) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		action <= act;
		slope <= m;
		intercept <= b;
		point <= x;
		@(posedge clk);
		while (busy) @(posedge clk);
		pending_results.insert(pending_results.size(), predict_hull(act, m, b, x));
		if (act == mcht_pkg::ACT_ADD) adds_sent++;
		else queries_sent++;
	endtask

	task automatic drain_results();
		start <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	// next slope below the previous one unless it wraps, mostly decreasing by small random steps
	task automatic add_ordered(int span);
		logic signed [mcht_pkg::ICPT_W-1:0] b;
		last_slope = last_slope - mcht_pkg::SLOPE_W'($urandom_range(span, 1));
		b = mcht_pkg::ICPT_W'({$urandom, $urandom}) >>> $urandom_range(40, 0);
		send_request(mcht_pkg::ACT_ADD, last_slope, b, mcht_pkg::POINT_W'($urandom));
	endtask

	task automatic query_ordered(int step);
		last_point = last_point + mcht_pkg::POINT_W'($urandom_range(step, 0));
		send_request(mcht_pkg::ACT_QUERY, mcht_pkg::SLOPE_W'($urandom),
			mcht_pkg::ICPT_W'({$urandom, $urandom}), last_point);
	endtask

	task automatic test_directed();
		send_request(mcht_pkg::ACT_QUERY, '0, '0, '0);
		send_request(mcht_pkg::ACT_ADD, 32'sh7fffffff, 56'sh7fffffffffffff, '0);
		send_request(mcht_pkg::ACT_ADD, 32'sh0, 56'sh0, 32'sh7fffffff);
		send_request(mcht_pkg::ACT_ADD, 32'sh0, -56'sd5, '0);
		send_request(mcht_pkg::ACT_ADD, 32'sh80000000, 56'sh80000000000000, '0);
		send_request(mcht_pkg::ACT_QUERY, '1, '1, 32'sh80000000);
		send_request(mcht_pkg::ACT_QUERY, '0, '0, -32'sd1);
		send_request(mcht_pkg::ACT_QUERY, '0, '0, 32'sh7fffffff);
		// point going backward and rising slope
		send_request(mcht_pkg::ACT_QUERY, '0, '0, -32'sd100);
		send_request(mcht_pkg::ACT_ADD, 32'sd50, 56'sd7, '0);
		send_request(mcht_pkg::ACT_ADD, 32'sd50, 56'sd3, '0);
		send_request(mcht_pkg::ACT_QUERY, '0, '0, 32'sd0);
		drain_results();
	endtask

	task automatic test_random(int n);
		int i;
		last_slope = 32'sh7fffffff;
		last_point = 32'sh80000000;
		for (i = 0; i < n; i++) begin
			if (i == n / 2) begin
				// everything in flight comes back before going on
				drain_results();
				no_gaps = 1'b1;
			end
			if (i == n / 2 + 150) no_gaps = 1'b0;
			case ($urandom_range(9))
				0: send_request(1'($urandom_range(1)), mcht_pkg::SLOPE_W'($urandom),
					mcht_pkg::ICPT_W'({$urandom, $urandom}), mcht_pkg::POINT_W'($urandom));
				1, 2, 3, 4: add_ordered(($urandom_range(3) == 0) ? 32'h3fffffff : 3000);
				default: query_ordered(($urandom_range(3) == 0) ? 20000000 : 50);
			endcase
		end
		drain_results();
	endtask

	always @(posedge clk) begin
		hull_result_t exp_r;
		if (done) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result value=%0d", min_value);
			end else begin
				exp_r = pending_results[0];
				pending_results.delete(0);
				if (exp_r.refused) refusals_seen++;
				if (exp_r.empty) empties_seen++;
				if (min_value !== exp_r.value || hull_empty !== exp_r.empty
						|| add_refused !== exp_r.refused) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected value=%0d empty=%0b refused=%0b, got %0d %0b %0b",
							exp_r.value, exp_r.empty, exp_r.refused,
							min_value, hull_empty, add_refused);
				end
			end
		end
	end

	// watchdog on cycles with no accepted request or result
	always @(posedge clk) begin
		if (!arst_n || done || (start && !busy)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WATCHDOG_LIMIT) begin
			timed_out = 1'b1;
			$display("[monotone_convex_hull_trick] ERROR");
			$finish;
		end
	end

	initial begin
		start = 1'b0;
		action = mcht_pkg::ACT_ADD;
		slope = '0;
		intercept = '0;
		point = '0;
		arst_n = 1'b0;
		mismatches = 0;
		results_seen = 0;
		adds_sent = 0;
		queries_sent = 0;
		refusals_seen = 0;
		empties_seen = 0;
		idle_cycles = 0;
		timed_out = 1'b0;
		no_gaps = 1'b0;
		hull_front = 0;
		hull_count = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(790);
		$display("covered %0d adds, %0d queries, %0d refused adds, %0d empty queries",
			adds_sent, queries_sent, refusals_seen, empties_seen);
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("[monotone_convex_hull_trick] OK");
		end else begin
			$display("[monotone_convex_hull_trick] ERROR");
		end
		$finish;
	end

endmodule

// File: filelist.f
src/mcht_pkg.sv
src/mcht_ram.sv
src/mcht_front.sv
src/mcht_back.sv
src/monotone_convex_hull_trick.sv
tb/sv/tb.sv
